### hw/rtl/lstg_pkg.sv
// Package for the leg step trajectory generator.
// Holds constants, config register codes, controller/datapath interface types and leg tables.
// No dependencies.
package lstg_pkg;

    localparam int MAX_POINTS_DEF = 255;
    localparam int MIN_POINTS     = 10;
    localparam int DIV_STEPS      = 24;   // 8-bit index followed by 16 fraction bits
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [2:0]  LEG_SELECT_RST  = 3'd1;
    localparam logic [12:0] STEP_LEN_RST    = 13'd1536;
    localparam logic [11:0] LIFT_H_RST      = 12'd1024;
    localparam logic [7:0]  POINT_COUNT_RST = 8'd200;

    localparam logic signed [15:0] BASE_Z_Q = -16'sd6144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEG_SELECT  = 2'd0,
        CFG_STEP_LEN    = 2'd1,
        CFG_LIFT_H      = 2'd2,
        CFG_POINT_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    // leg 0 behaves as leg 1, leg 7 as leg 6
    function automatic logic signed [15:0] leg_base_x(input logic [2:0] leg);
        logic signed [15:0] v;
        case (leg)
            3'd0, 3'd1: v = 16'sd4608;
            3'd2:       v = -16'sd4608;
            3'd3:       v = 16'sd5632;
            3'd4:       v = -16'sd5632;
            3'd5:       v = 16'sd4608;
            default:    v = -16'sd4608;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] leg_base_y(input logic [2:0] leg);
        logic signed [15:0] v;
        case (leg)
            3'd0, 3'd1, 3'd2: v = -16'sd3840;
            3'd3, 3'd4:       v = 16'sd0;
            default:          v = 16'sd3840;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/lstg_ctrl.sv
// Controller FSM for the leg step trajectory generator.
// Sequences load, divide, multiply and output steps of the datapath. Uses lstg_pkg.
module lstg_ctrl import lstg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int CntW = $clog2(DIV_STEPS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_MUL3 = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CntW'(DIV_STEPS - 1)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result loaded into a busy output register");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> ##(DIV_STEPS + 1) o_cmd.mul1)
        else $error("divide did not take the full step count");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");
`endif

endmodule

### hw/rtl/lstg_dp.sv
// Datapath for the leg step trajectory generator.
// Config registers, step bookkeeping, serial divider, multiply steps and output register.
// Uses lstg_pkg; driven by lstg_ctrl.
module lstg_dp import lstg_pkg::*; #(
    parameter int P_MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_start_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [55:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int PtsW = $clog2(P_MAX_POINTS + 1);
    localparam int CmpW = (PtsW > 8) ? PtsW : 8;

    // config
    logic [2:0]  r_leg;
    logic [12:0] r_step;
    logic [11:0] r_lift;
    logic [7:0]  r_npts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leg  <= LEG_SELECT_RST;
            r_step <= STEP_LEN_RST;
            r_lift <= LIFT_H_RST;
            r_npts <= POINT_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEG_SELECT:  r_leg  <= i_cfg_wdata[2:0];
                CFG_STEP_LEN:    r_step <= i_cfg_wdata[12:0];
                CFG_LIFT_H:      r_lift <= i_cfg_wdata[11:0];
                CFG_POINT_COUNT: r_npts <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // phase lengths: swing = floor(3N/5) via 615/1024 = 3 * 205/1024
    logic [CmpW-1:0] w_n_ext;
    logic [7:0]      w_n;
    logic [18:0]     w_sw_prod;
    logic [7:0]      w_sw;
    logic [7:0]      w_st;

    always_comb begin
        w_n_ext = CmpW'(r_npts);
        if (w_n_ext < CmpW'(MIN_POINTS)) begin
            w_n_ext = CmpW'(MIN_POINTS);
        end
        if (w_n_ext > CmpW'(P_MAX_POINTS)) begin
            w_n_ext = CmpW'(P_MAX_POINTS);
        end
        w_n       = w_n_ext[7:0];
        w_sw_prod = 19'(w_n) * 19'd615;
        w_sw      = w_sw_prod[17:10];
        w_st      = w_n - w_sw;
    end

    // step bookkeeping
    logic       r_run, n_run;
    logic       r_ph, n_ph;
    logic [7:0] r_idx, n_idx;
    logic [7:0] w_cur_end, w_end;

    always_comb begin
        n_run     = r_run;
        n_ph      = r_ph;
        n_idx     = r_idx;
        w_cur_end = r_ph ? w_st : w_sw;
        if (i_start_req) begin
            n_run = 1'b1;
            n_ph  = 1'b0;
            n_idx = '0;
        end else if (r_run) begin
            if (r_idx >= w_cur_end) begin
                if (!r_ph) begin
                    n_ph  = 1'b1;
                    n_idx = '0;
                end else begin
                    n_run = 1'b0;
                    n_ph  = 1'b0;
                    n_idx = '0;
                end
            end else begin
                n_idx = r_idx + 8'd1;
            end
        end
        w_end = n_ph ? w_st : w_sw;
        if (n_run && n_idx > w_end) begin
            n_idx = w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_ph  <= 1'b0;
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_run <= n_run;
            r_ph  <= n_ph;
            r_idx <= n_idx;
        end
    end

    // restoring divider: t = (idx << 16) / end
    logic [7:0]  r_den;
    logic [7:0]  r_rem;
    logic [23:0] r_quo;
    logic [8:0]  w_rem_sh;
    logic        w_qbit;

    assign w_rem_sh = {r_rem, r_quo[23]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= w_end;
            r_rem <= '0;
            r_quo <= {n_idx, 16'd0};
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? 8'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[7:0];
            r_quo <= {r_quo[22:0], w_qbit};
        end
    end

    // multiply steps
    logic [16:0] w_t, w_tc;
    logic [33:0] w_t2p, w_up;
    logic [34:0] w_sp;
    logic [42:0] w_ap;
    logic [29:0] w_dp;
    logic [16:0] r_t2;
    logic [30:0] r_u;
    logic [17:0] r_w;
    logic [16:0] r_s;
    logic [11:0] r_arc;
    logic [12:0] r_d;

    assign w_t   = r_quo[16:0];
    assign w_tc  = 17'(18'h10000 - 18'(w_t));
    assign w_t2p = 34'(w_t) * 34'(w_t);
    assign w_up  = 34'(w_t) * 34'(w_tc);
    assign w_sp  = 35'(r_t2) * 35'(r_w);
    assign w_ap  = 43'(r_lift) * 43'(r_u);
    assign w_dp  = 30'(r_step) * 30'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_t2 <= w_t2p[32:16];
            r_u  <= w_up[30:0];
            r_w  <= 18'(18'h30000 - {w_t, 1'b0});
        end
        if (i_cmd.mul2) begin
            r_s   <= w_sp[32:16];
            r_arc <= w_ap[41:30];
        end
        if (i_cmd.mul3) begin
            r_d <= w_dp[28:16];
        end
    end

    // result assembly and output register
    logic signed [15:0] w_bx, w_by, w_y, w_z;
    logic               w_last;

    always_comb begin
        w_bx   = leg_base_x(r_leg);
        w_by   = leg_base_y(r_leg);
        w_y    = w_by;
        w_z    = BASE_Z_Q;
        w_last = 1'b0;
        if (r_run) begin
            if (!r_ph) begin
                w_y = w_by - signed'({3'd0, r_d});
                w_z = BASE_Z_Q - signed'({4'd0, r_arc});
            end else begin
                w_y    = w_by - signed'({3'd0, r_step}) + signed'({3'd0, r_d});
                w_last = (r_idx == r_den);
            end
        end
    end

    logic        r_out_valid;
    logic [55:0] r_out_data;
    logic [1:0]  r_out_user;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {(r_run ? r_idx : 8'd0), w_z, w_y, w_bx};
            r_out_user <= {r_run, r_run & r_ph};
            r_out_last <= w_last;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_m_tuser       = r_out_user;
    assign o_m_tlast       = r_out_last;

`ifndef ASSERT_OFF
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && i_start_req |=> r_run && !r_ph && r_idx == 8'd0)
        else $error("restart did not return to swing point zero");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_idx <= r_den)
        else $error("waypoint index beyond end of phase");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> r_rem < r_den)
        else $error("divider remainder out of range");
`endif

endmodule

### hw/rtl/leg_step_trajectory_generator.sv
// Top level of the leg step trajectory generator.
// Instantiates lstg_ctrl (FSM) and lstg_dp (datapath); uses lstg_pkg.
//
// Every request on the slave stream yields one foot waypoint on the master stream:
// start_req restarts the step at swing point zero, otherwise the step advances one point.
// Swing has floor(3N/5)+1 points with smoothstep y and a parabolic z lift; stance returns
// along the ground. When no step runs, the idle base position is returned with active low.
// A request runs from acceptance through the bit-serial divider that forms t, then three
// multiply steps, the output load and the output register.
// One request is in flight at a time, so a new request is taken only once the last one's
// result is loaded; the output register lets the next request in while a result waits.
// Config writes are taken any cycle but must only occur while the block is idle.
module leg_step_trajectory_generator import lstg_pkg::*; #(
    parameter int P_MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] start_req
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // pos_x, pos_y, pos_z, point_index
    output logic [1:0]            m_axis_tuser,   // phase, active
    output logic                  m_axis_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lstg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lstg_dp #(
        .P_MAX_POINTS (P_MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start_req (s_axis_tdata[0]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule
